// ===== design/bkv_pkg.sv =====
// Shared types, keyword tables and character helpers for the brace-block key/value parser.
`timescale 1ns / 1ps

package bkv_pkg;

  localparam int unsigned NumNames  = 7;
  localparam int unsigned NumTypes  = 9;
  localparam int unsigned KwBytes   = 16;
  localparam int unsigned KwW       = 8 * KwBytes;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  typedef logic [KwW-1:0]    kw_t;
  typedef logic [FifoPtrW:0] fifo_cnt_t;
  typedef logic [FifoPtrW-1:0] fifo_ptr_t;

  // Keywords are right-justified in the vector: the first character sits highest.
  localparam kw_t NAME_WORDS [NumNames] = '{
    "type", "part", "data", "option", "id", "target", "file"
  };
  localparam logic [4:0] NAME_LENS [NumNames] = '{
    5'd4, 5'd4, 5'd4, 5'd6, 5'd2, 5'd6, 5'd4
  };

  localparam kw_t TYPE_WORDS [NumTypes] = '{
    "access", "access,operation", "color", "drag", "image",
    "info", "script", "signal", "text"
  };
  localparam logic [4:0] TYPE_LENS [NumTypes] = '{
    5'd6, 5'd16, 5'd5, 5'd4, 5'd5, 5'd4, 5'd6, 5'd6, 5'd4
  };

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [4:0] POS_MAX  = 5'd31;

  typedef enum logic [2:0] {
    EV_VALUE_BYTE  = 3'd0,
    EV_VALUE_END   = 3'd1,
    EV_BLOCK_OPEN  = 3'd2,
    EV_BLOCK_CLOSE = 3'd3,
    EV_ERROR       = 3'd4,
    EV_TEXT_OK     = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    ERR_FIELD_NAME   = 2'd0,
    ERR_TYPE         = 2'd1,
    ERR_EOT_IN_BLOCK = 2'd2
  } err_e;

  typedef struct packed {
    event_e      ev;
    logic [2:0]  field;
    logic [3:0]  type_code;
    logic [7:0]  value;
    err_e        err;
    logic        last;
  } res_t;

  // Results produced by one accepted byte: none, one or two.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  typedef struct packed {
    fifo_cnt_t count;
  } fifo_stat_t;

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_term(logic [7:0] c);
    return (c == 8'h0A) || (c == 8'h0D) || (c == 8'h0C);
  endfunction

  // True when the keyword still has a character at pos and it equals c.
  function automatic logic kw_hit(kw_t word, logic [4:0] len, logic [4:0] pos,
                                  logic [7:0] c);
    logic [3:0] idx;
    idx = 4'(len - pos - 5'd1);
    return (pos < len) && (word[{idx, 3'b000} +: 8] == c);
  endfunction

endpackage

// ===== design/bkv_if.sv =====
// Stream interfaces for the parser's byte input and result output.
`timescale 1ns / 1ps

interface bkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bkv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] field_code;
  logic [3:0] type_code;
  logic [7:0] value_byte;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output event_res, output field_code, output type_code,
                  output value_byte, output error_code, output last, input ready);
  modport sink   (input valid, input event_res, input field_code, input type_code,
                  input value_byte, input error_code, input last, output ready);
endinterface

// ===== design/bkv_parse_core.sv =====
// Parser state and per-byte next-state and result logic.
`timescale 1ns / 1ps

module bkv_parse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              eot_i,
  output bkv_pkg::push_t    push_o
);

  typedef enum logic [2:0] {
    PH_OUTSIDE = 3'd0,
    PH_FIELD   = 3'd1,
    PH_VALUE   = 3'd2,
    PH_AFTER   = 3'd3,
    PH_ERROR   = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  field_q, field_d;
  logic [6:0]  name_cand_q, name_cand_d;
  logic [8:0]  type_cand_q, type_cand_d;
  logic [4:0]  pos_q, pos_d;
  logic        started_q, started_d;

  logic [6:0]  nm_cand_in;
  logic [4:0]  nm_pos_in;
  logic [4:0]  nm_pos_inc;
  logic [6:0]  nm_narrow;
  logic        nm_hit_vld;
  logic [2:0]  nm_hit;
  logic [8:0]  ty_narrow;
  logic        ty_hit_vld;
  logic [3:0]  ty_hit;
  logic [4:0]  ty_pos_inc;

  // Keyword matching: a new name restarts from the full set at position zero.
  always_comb begin
    nm_cand_in = (phase_q == PH_AFTER) ? '1 : name_cand_q;
    nm_pos_in  = (phase_q == PH_AFTER) ? '0 : pos_q;
    nm_pos_inc = (nm_pos_in != bkv_pkg::POS_MAX) ? nm_pos_in + 5'd1 : nm_pos_in;
    ty_pos_inc = (pos_q != bkv_pkg::POS_MAX) ? pos_q + 5'd1 : pos_q;
    nm_hit_vld = 1'b0;
    nm_hit     = '0;
    ty_hit_vld = 1'b0;
    ty_hit     = '0;
    for (int i = 0; i < bkv_pkg::NumNames; i++) begin
      nm_narrow[i] = nm_cand_in[i] &&
        bkv_pkg::kw_hit(bkv_pkg::NAME_WORDS[i], bkv_pkg::NAME_LENS[i], nm_pos_in, byte_i);
    end
    for (int i = bkv_pkg::NumNames - 1; i >= 0; i--) begin
      if (nm_cand_in[i] && (bkv_pkg::NAME_LENS[i] == nm_pos_in)) begin
        nm_hit_vld = 1'b1;
        nm_hit     = 3'(i);
      end
    end
    for (int i = 0; i < bkv_pkg::NumTypes; i++) begin
      ty_narrow[i] = type_cand_q[i] &&
        bkv_pkg::kw_hit(bkv_pkg::TYPE_WORDS[i], bkv_pkg::TYPE_LENS[i], pos_q, byte_i);
    end
    for (int i = bkv_pkg::NumTypes - 1; i >= 0; i--) begin
      if (type_cand_q[i] && (bkv_pkg::TYPE_LENS[i] == pos_q)) begin
        ty_hit_vld = 1'b1;
        ty_hit     = 4'(i);
      end
    end
  end

  logic            p_vld, e_vld, run_name;
  bkv_pkg::res_t   p_res, e_res;

  always_comb begin
    phase_d     = phase_q;
    field_d     = field_q;
    name_cand_d = name_cand_q;
    type_cand_d = type_cand_q;
    pos_d       = pos_q;
    started_d   = started_q;
    p_vld       = 1'b0;
    p_res       = '0;
    e_vld       = 1'b0;
    e_res       = '0;
    run_name    = 1'b0;

    if (byte_i != bkv_pkg::CH_NUL) begin
      unique case (phase_q)
        PH_OUTSIDE: begin
          if (byte_i == bkv_pkg::CH_OPEN) begin
            p_vld       = 1'b1;
            p_res.ev    = bkv_pkg::EV_BLOCK_OPEN;
            name_cand_d = '1;
            pos_d       = '0;
            phase_d     = PH_FIELD;
          end
        end
        PH_FIELD: begin
          run_name = 1'b1;
        end
        PH_VALUE: begin
          if (field_q != 3'd0) begin
            p_vld       = 1'b1;
            p_res.field = field_q;
            if (bkv_pkg::is_term(byte_i)) begin
              p_res.ev = bkv_pkg::EV_VALUE_END;
              phase_d  = PH_AFTER;
            end else begin
              p_res.ev    = bkv_pkg::EV_VALUE_BYTE;
              p_res.value = byte_i;
            end
          end else if (started_q || !bkv_pkg::is_blank(byte_i)) begin
            started_d = 1'b1;
            p_vld     = 1'b1;
            if (bkv_pkg::is_term(byte_i)) begin
              if (!ty_hit_vld) begin
                p_res.ev  = bkv_pkg::EV_ERROR;
                p_res.err = bkv_pkg::ERR_TYPE;
                phase_d   = PH_ERROR;
              end else begin
                p_res.ev        = bkv_pkg::EV_VALUE_END;
                p_res.type_code = ty_hit;
                phase_d         = PH_AFTER;
              end
            end else begin
              type_cand_d = ty_narrow;
              if (ty_narrow == '0) begin
                p_res.ev  = bkv_pkg::EV_ERROR;
                p_res.err = bkv_pkg::ERR_TYPE;
                phase_d   = PH_ERROR;
              end else begin
                p_res.ev    = bkv_pkg::EV_VALUE_BYTE;
                p_res.value = byte_i;
                pos_d       = ty_pos_inc;
              end
            end
          end
        end
        PH_AFTER: begin
          if (bkv_pkg::is_blank(byte_i)) begin
            // skip
          end else if (byte_i == bkv_pkg::CH_CLOSE) begin
            p_vld    = 1'b1;
            p_res.ev = bkv_pkg::EV_BLOCK_CLOSE;
            phase_d  = PH_OUTSIDE;
          end else begin
            phase_d     = PH_FIELD;
            name_cand_d = '1;
            pos_d       = '0;
            run_name    = 1'b1;
          end
        end
        PH_ERROR: begin
        end
        default: begin
        end
      endcase
    end

    // Name character: blanks vanish, '=' closes the name, else narrow the set.
    if (run_name && !bkv_pkg::is_blank(byte_i)) begin
      if (byte_i == bkv_pkg::CH_EQ) begin
        if (!nm_hit_vld) begin
          p_vld     = 1'b1;
          p_res.ev  = bkv_pkg::EV_ERROR;
          p_res.err = bkv_pkg::ERR_FIELD_NAME;
          phase_d   = PH_ERROR;
        end else begin
          field_d     = nm_hit;
          type_cand_d = '1;
          pos_d       = '0;
          started_d   = 1'b0;
          phase_d     = PH_VALUE;
        end
      end else begin
        name_cand_d = nm_narrow;
        if (nm_narrow == '0) begin
          p_vld     = 1'b1;
          p_res.ev  = bkv_pkg::EV_ERROR;
          p_res.err = bkv_pkg::ERR_FIELD_NAME;
          phase_d   = PH_ERROR;
        end else begin
          pos_d = nm_pos_inc;
        end
      end
    end

    // End of text (NUL byte or eot flag): report unless in error, then return to the reset state.
    if ((byte_i == bkv_pkg::CH_NUL) || eot_i) begin
      if (phase_d == PH_OUTSIDE) begin
        e_vld    = 1'b1;
        e_res.ev = bkv_pkg::EV_TEXT_OK;
      end else if (phase_d != PH_ERROR) begin
        e_vld     = 1'b1;
        e_res.ev  = bkv_pkg::EV_ERROR;
        e_res.err = bkv_pkg::ERR_EOT_IN_BLOCK;
      end
      phase_d     = PH_OUTSIDE;
      field_d     = '0;
      name_cand_d = '1;
      type_cand_d = '1;
      pos_d       = '0;
      started_d   = 1'b0;
    end
  end

  always_comb begin
    push_o.cnt  = step_i ? ({1'b0, p_vld} + {1'b0, e_vld}) : 2'd0;
    push_o.res0 = p_vld ? p_res : e_res;
    push_o.res1 = e_res;
    if (p_vld && e_vld) begin
      push_o.res1.last = 1'b1;
    end else begin
      push_o.res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OUTSIDE;
      field_q     <= '0;
      name_cand_q <= '1;
      type_cand_q <= '1;
      pos_q       <= '0;
      started_q   <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      field_q     <= field_d;
      name_cand_q <= name_cand_d;
      type_cand_q <= type_cand_d;
      pos_q       <= pos_d;
      started_q   <= started_d;
    end
  end

endmodule

// ===== design/bkv_result_fifo.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module bkv_result_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bkv_pkg::push_t       push_i,
  input  logic                 pop_i,
  output bkv_pkg::res_t        head_o,
  output bkv_pkg::fifo_stat_t  stat_o
);

  bkv_pkg::res_t        mem_q [bkv_pkg::FifoDepth];
  bkv_pkg::fifo_ptr_t   wr_q, rd_q;
  bkv_pkg::fifo_cnt_t   cnt_q, cnt_d;

  assign head_o       = mem_q[rd_q];
  assign stat_o.count = cnt_q;

  always_comb begin
    cnt_d = cnt_q + bkv_pkg::fifo_cnt_t'(push_i.cnt) - bkv_pkg::fifo_cnt_t'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + bkv_pkg::fifo_ptr_t'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + bkv_pkg::fifo_ptr_t'(push_i.cnt);
      rd_q  <= rd_q + bkv_pkg::fifo_ptr_t'(pop_i);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/brace_block_keyvalue_parser_unit.sv =====
// Top level of the brace-block key/value text parser.
`timescale 1ns / 1ps

// Streaming parser for text made of { name=value } blocks. One text byte is
// taken per beat and fully parsed in the same cycle: the parser state lives in
// bkv_parse_core, and the zero, one or two results a byte causes are written
// into a four-entry result queue in that cycle. Results leave one per beat on
// the output channel, in order, with last set on the final result of each
// byte. The input is ready whenever the queue has room for two results, that
// is with at most two results waiting; the results of an accepted byte are
// registered in the queue before they reach the output. Only a byte that ends
// the text can cause two results. While the output drains every cycle the
// rate holds at one byte per cycle, except for an input stall when a
// two-result byte arrives with two results already queued; a stalled output
// stops the input once three results wait. Errors are sticky until the end of
// the text, after which the parser is back in its reset state.

module brace_block_keyvalue_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bkv_in_if.sink     in_i,
  bkv_out_if.source  out_o
);

  logic                 step;
  logic                 pop;
  bkv_pkg::push_t       push;
  bkv_pkg::res_t        head;
  bkv_pkg::fifo_stat_t  stat;

  // Accept a beat only with room for the worst case of two results.
  assign in_i.ready = (stat.count <= bkv_pkg::fifo_cnt_t'(bkv_pkg::FifoDepth - 2));
  assign step       = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  bkv_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_i.text_byte),
    .eot_i  (in_i.end_of_text),
    .push_o (push)
  );

  bkv_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  // Drive the output beat from the queue head.
  assign out_o.valid      = (stat.count != '0);
  assign out_o.event_res  = head.ev;
  assign out_o.field_code = head.field;
  assign out_o.type_code  = head.type_code;
  assign out_o.value_byte = head.value;
  assign out_o.error_code = head.err;
  assign out_o.last       = head.last;

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= bkv_pkg::fifo_cnt_t'(bkv_pkg::FifoDepth))
    else $error("result queue overflow");

  // A second result from one byte can only be the end-of-text report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (push.cnt == 2'd2)) |->
      ((push.res1.ev == bkv_pkg::EV_TEXT_OK) ||
       ((push.res1.ev == bkv_pkg::EV_ERROR) &&
        (push.res1.err == bkv_pkg::ERR_EOT_IN_BLOCK))))
    else $error("second result of a byte is not an end-of-text report");

  // A result that is not last has its sibling queued right behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> (stat.count >= bkv_pkg::fifo_cnt_t'(2)))
    else $error("non-last result without its sibling");

endmodule
